// File: design/lpa_pkg.sv
// lpa_pkg: shared types and constants for the linked pool allocator.
// No dependencies; used by linked_pool_allocator and lpa_checker.
`default_nettype none

package lpa_pkg;

    localparam int CMD_W   = 2;
    localparam int ENTRY_W = 6;
    localparam int GROUP_W = 8;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_KILL   = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic {
        LIST_ACTIVE = 1'b0,
        LIST_GROUP  = 1'b1
    } list_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CREATE,
        ST_CHECK,
        ST_UL_START,
        ST_UL_HEAD,
        ST_UL_WALK,
        ST_UL_END,
        ST_FREE,
        ST_MV_PUSH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: design/lpa_ram.sv
// lpa_ram: simple dual-port RAM, one write port, one registered read port.
// No dependencies; instantiated by linked_pool_allocator for each link store.
`default_nettype none

module lpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/linked_pool_allocator.sv
// linked_pool_allocator: pool of entries on free, active and per-group linked lists.
// Depends on lpa_pkg (types, codes) and lpa_ram (link and head stores).
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------------
//  in      | cmd[1:0] entry_index[5:0] group_index[7:0]| in  | in_valid / in_ready
//  out     | status result_index[5:0]                  | out | out_valid / out_ready
//
// Kill and move of a live entry walk the lists, reading one link per cycle from a
// single-port-read link store. After reset a clearing pass initializes the free chain,
// group heads and allocated bits; in_ready stays low during it.
// in_ready is high only while idle; a result waits in an output register meanwhile.
`default_nettype none

module linked_pool_allocator #(
    parameter int POOL_SIZE   = 64,
    parameter int GROUP_COUNT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lpa_pkg::CMD_W-1:0]     cmd,
    input  wire logic [lpa_pkg::ENTRY_W-1:0]   entry_index,
    input  wire logic [lpa_pkg::GROUP_W-1:0]   group_index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               status,
    output logic [lpa_pkg::ENTRY_W-1:0]        result_index
);

    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int IW = $clog2(POOL_SIZE);
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int INIT_DEPTH = (POOL_SIZE > GROUP_COUNT) ? POOL_SIZE : GROUP_COUNT;
    localparam int CW = $clog2(INIT_DEPTH);
    localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);

    // group_index modulo GROUP_COUNT by restoring reduction, eight steps
    function automatic logic [GW-1:0] group_mod(input logic [lpa_pkg::GROUP_W-1:0] g);
        logic [19:0] r;
        r = 20'(g);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (20'(GROUP_COUNT) << k))
            begin
                r = r - (20'(GROUP_COUNT) << k);
            end
        end
        return GW'(r);
    endfunction

    lpa_pkg::state_t    state_reg, state_next;
    lpa_pkg::cmd_t      cmd_reg, cmd_next;
    lpa_pkg::list_sel_t sel_reg, sel_next;

    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] active_head_reg, active_head_next;
    logic [LW-1:0] entry_reg, entry_next;
    logic          entry_bad_reg, entry_bad_next;
    logic [GW-1:0] group_reg, group_next;
    logic [GW-1:0] old_group_reg, old_group_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [LW-1:0] link_e_reg, link_e_next;
    logic [CW-1:0] init_cnt_reg, init_cnt_next;
    logic          res_status_reg, res_status_next;
    logic [lpa_pkg::ENTRY_W-1:0] res_idx_reg, res_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_status_reg;
    logic [lpa_pkg::ENTRY_W-1:0] out_idx_reg;
    logic          out_load;

    // store ports
    logic          ngl_we, nal_we, egr_we, ghd_we, liv_we;
    logic [IW-1:0] ngl_waddr, nal_waddr, egr_waddr, liv_waddr;
    logic [IW-1:0] ngl_raddr, nal_raddr, egr_raddr, liv_raddr;
    logic [GW-1:0] ghd_waddr, ghd_raddr;
    logic [LW-1:0] ngl_wdata, nal_wdata, ghd_wdata;
    logic [LW-1:0] ngl_rdata, nal_rdata, ghd_rdata;
    logic [GW-1:0] egr_wdata, egr_rdata;
    logic          liv_wdata, liv_rdata;

    logic [LW-1:0] link_rd;
    logic [LW-1:0] head_rd;

    lpa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_ngl (
        .clk(clk), .we(ngl_we), .waddr(ngl_waddr), .wdata(ngl_wdata),
        .raddr(ngl_raddr), .rdata(ngl_rdata)
    );

    lpa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_nal (
        .clk(clk), .we(nal_we), .waddr(nal_waddr), .wdata(nal_wdata),
        .raddr(nal_raddr), .rdata(nal_rdata)
    );

    lpa_ram #(.WIDTH(GW), .DEPTH(POOL_SIZE)) u_egr (
        .clk(clk), .we(egr_we), .waddr(egr_waddr), .wdata(egr_wdata),
        .raddr(egr_raddr), .rdata(egr_rdata)
    );

    lpa_ram #(.WIDTH(LW), .DEPTH(GROUP_COUNT)) u_ghd (
        .clk(clk), .we(ghd_we), .waddr(ghd_waddr), .wdata(ghd_wdata),
        .raddr(ghd_raddr), .rdata(ghd_rdata)
    );

    lpa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_liv (
        .clk(clk), .we(liv_we), .waddr(liv_waddr), .wdata(liv_wdata),
        .raddr(liv_raddr), .rdata(liv_rdata)
    );

    // walk engine sees one list at a time
    assign link_rd = (sel_reg == lpa_pkg::LIST_ACTIVE) ? nal_rdata : ngl_rdata;
    assign head_rd = (sel_reg == lpa_pkg::LIST_ACTIVE) ? active_head_reg : ghd_rdata;

    assign in_ready     = (state_reg == lpa_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_index = out_idx_reg;
    assign out_load     = (state_reg == lpa_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpa_pkg::ST_INIT:
            begin
                if (init_cnt_reg == CW'(INIT_DEPTH - 1))
                begin
                    state_next = lpa_pkg::ST_IDLE;
                end
            end
            lpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lpa_pkg::ST_DISPATCH;
                end
            end
            lpa_pkg::ST_DISPATCH:
            begin
                case (cmd_reg)
                    lpa_pkg::CMD_CREATE:
                        state_next = (free_head_reg >= NONE) ? lpa_pkg::ST_DONE
                                                             : lpa_pkg::ST_CREATE;
                    lpa_pkg::CMD_KILL,
                    lpa_pkg::CMD_MOVE:
                        state_next = entry_bad_reg ? lpa_pkg::ST_DONE : lpa_pkg::ST_CHECK;
                    default:
                        state_next = lpa_pkg::ST_DONE;
                endcase
            end
            lpa_pkg::ST_CREATE:
                state_next = lpa_pkg::ST_DONE;
            lpa_pkg::ST_CHECK:
                state_next = liv_rdata ? lpa_pkg::ST_UL_START : lpa_pkg::ST_DONE;
            lpa_pkg::ST_UL_START:
                state_next = lpa_pkg::ST_UL_HEAD;
            lpa_pkg::ST_UL_HEAD:
            begin
                if ((head_rd == entry_reg) || (head_rd >= NONE))
                begin
                    state_next = lpa_pkg::ST_UL_END;
                end
                else
                begin
                    state_next = lpa_pkg::ST_UL_WALK;
                end
            end
            lpa_pkg::ST_UL_WALK:
            begin
                if ((link_rd == entry_reg) || (link_rd >= NONE) ||
                    (steps_reg == LW'(POOL_SIZE - 1)))
                begin
                    state_next = lpa_pkg::ST_UL_END;
                end
            end
            lpa_pkg::ST_UL_END:
            begin
                if (sel_reg == lpa_pkg::LIST_ACTIVE)
                begin
                    state_next = lpa_pkg::ST_UL_START;
                end
                else if (cmd_reg == lpa_pkg::CMD_KILL)
                begin
                    state_next = lpa_pkg::ST_FREE;
                end
                else
                begin
                    state_next = lpa_pkg::ST_MV_PUSH;
                end
            end
            lpa_pkg::ST_FREE:
                state_next = lpa_pkg::ST_DONE;
            lpa_pkg::ST_MV_PUSH:
                state_next = lpa_pkg::ST_DONE;
            lpa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = lpa_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lpa_pkg::ST_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        cmd_next         = cmd_reg;
        sel_next         = sel_reg;
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        entry_next       = entry_reg;
        entry_bad_next   = entry_bad_reg;
        group_next       = group_reg;
        old_group_next   = old_group_reg;
        cur_next         = cur_reg;
        steps_next       = steps_reg;
        link_e_next      = link_e_reg;
        init_cnt_next    = init_cnt_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;

        ngl_we = 1'b0; ngl_waddr = '0; ngl_wdata = '0; ngl_raddr = '0;
        nal_we = 1'b0; nal_waddr = '0; nal_wdata = '0; nal_raddr = '0;
        egr_we = 1'b0; egr_waddr = '0; egr_wdata = '0; egr_raddr = '0;
        ghd_we = 1'b0; ghd_waddr = '0; ghd_wdata = '0; ghd_raddr = '0;
        liv_we = 1'b0; liv_waddr = '0; liv_wdata = 1'b0; liv_raddr = '0;

        case (state_reg)
            lpa_pkg::ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + CW'(1);
                if (32'(init_cnt_reg) < POOL_SIZE)
                begin
                    ngl_we    = 1'b1;
                    ngl_waddr = init_cnt_reg[IW-1:0];
                    ngl_wdata = (init_cnt_reg == CW'(POOL_SIZE - 1)) ? NONE
                              : LW'(init_cnt_reg) + LW'(1);
                    liv_we    = 1'b1;
                    liv_waddr = init_cnt_reg[IW-1:0];
                    liv_wdata = 1'b0;
                end
                if (32'(init_cnt_reg) < GROUP_COUNT)
                begin
                    ghd_we    = 1'b1;
                    ghd_waddr = init_cnt_reg[GW-1:0];
                    ghd_wdata = NONE;
                end
            end
            lpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = lpa_pkg::cmd_t'(cmd);
                    entry_next      = LW'(entry_index);
                    entry_bad_next  = (32'(entry_index) >= POOL_SIZE);
                    group_next      = group_mod(group_index);
                    res_status_next = lpa_pkg::STATUS_DONE;
                    res_idx_next    = '0;
                end
            end
            lpa_pkg::ST_DISPATCH:
            begin
                case (cmd_reg)
                    lpa_pkg::CMD_CREATE:
                    begin
                        if (free_head_reg >= NONE)
                        begin
                            res_status_next = lpa_pkg::STATUS_FULL;
                        end
                        entry_next = free_head_reg;
                        ngl_raddr  = free_head_reg[IW-1:0];
                        ghd_raddr  = group_reg;
                    end
                    lpa_pkg::CMD_KILL,
                    lpa_pkg::CMD_MOVE:
                    begin
                        liv_raddr = entry_reg[IW-1:0];
                        egr_raddr = entry_reg[IW-1:0];
                    end
                    default:
                    begin
                        res_status_next = lpa_pkg::STATUS_DONE;
                    end
                endcase
            end
            lpa_pkg::ST_CREATE:
            begin
                free_head_next   = ngl_rdata;
                ngl_we           = 1'b1;
                ngl_waddr        = entry_reg[IW-1:0];
                ngl_wdata        = ghd_rdata;
                ghd_we           = 1'b1;
                ghd_waddr        = group_reg;
                ghd_wdata        = entry_reg;
                egr_we           = 1'b1;
                egr_waddr        = entry_reg[IW-1:0];
                egr_wdata        = group_reg;
                nal_we           = 1'b1;
                nal_waddr        = entry_reg[IW-1:0];
                nal_wdata        = active_head_reg;
                active_head_next = entry_reg;
                liv_we           = 1'b1;
                liv_waddr        = entry_reg[IW-1:0];
                liv_wdata        = 1'b1;
                res_idx_next     = lpa_pkg::ENTRY_W'(entry_reg);
            end
            lpa_pkg::ST_CHECK:
            begin
                old_group_next = egr_rdata;
                sel_next = (cmd_reg == lpa_pkg::CMD_KILL) ? lpa_pkg::LIST_ACTIVE
                                                          : lpa_pkg::LIST_GROUP;
            end
            lpa_pkg::ST_UL_START:
            begin
                // link of the entry itself, and the group head
                ngl_raddr = entry_reg[IW-1:0];
                nal_raddr = entry_reg[IW-1:0];
                ghd_raddr = old_group_reg;
            end
            lpa_pkg::ST_UL_HEAD:
            begin
                link_e_next = link_rd;
                if (head_rd == entry_reg)
                begin
                    if (sel_reg == lpa_pkg::LIST_ACTIVE)
                    begin
                        active_head_next = link_rd;
                    end
                    else
                    begin
                        ghd_we    = 1'b1;
                        ghd_waddr = old_group_reg;
                        ghd_wdata = link_rd;
                    end
                end
                else
                begin
                    cur_next   = head_rd;
                    steps_next = '0;
                    ngl_raddr  = head_rd[IW-1:0];
                    nal_raddr  = head_rd[IW-1:0];
                end
            end
            lpa_pkg::ST_UL_WALK:
            begin
                if (link_rd == entry_reg)
                begin
                    // bypass the entry: predecessor takes the entry's link
                    if (sel_reg == lpa_pkg::LIST_ACTIVE)
                    begin
                        nal_we    = 1'b1;
                        nal_waddr = cur_reg[IW-1:0];
                        nal_wdata = link_e_reg;
                    end
                    else
                    begin
                        ngl_we    = 1'b1;
                        ngl_waddr = cur_reg[IW-1:0];
                        ngl_wdata = link_e_reg;
                    end
                end
                else
                begin
                    cur_next   = link_rd;
                    steps_next = steps_reg + LW'(1);
                    ngl_raddr  = link_rd[IW-1:0];
                    nal_raddr  = link_rd[IW-1:0];
                end
            end
            lpa_pkg::ST_UL_END:
            begin
                if (sel_reg == lpa_pkg::LIST_ACTIVE)
                begin
                    sel_next = lpa_pkg::LIST_GROUP;
                end
                ghd_raddr = group_reg;
            end
            lpa_pkg::ST_FREE:
            begin
                ngl_we         = 1'b1;
                ngl_waddr      = entry_reg[IW-1:0];
                ngl_wdata      = free_head_reg;
                free_head_next = entry_reg;
                nal_we         = 1'b1;
                nal_waddr      = entry_reg[IW-1:0];
                nal_wdata      = NONE;
                liv_we         = 1'b1;
                liv_waddr      = entry_reg[IW-1:0];
                liv_wdata      = 1'b0;
            end
            lpa_pkg::ST_MV_PUSH:
            begin
                ngl_we    = 1'b1;
                ngl_waddr = entry_reg[IW-1:0];
                ngl_wdata = ghd_rdata;
                ghd_we    = 1'b1;
                ghd_waddr = group_reg;
                ghd_wdata = entry_reg;
                egr_we    = 1'b1;
                egr_waddr = entry_reg[IW-1:0];
                egr_wdata = group_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lpa_pkg::ST_INIT;
            init_cnt_reg    <= '0;
            free_head_reg   <= '0;
            active_head_reg <= NONE;
            out_valid_reg   <= 1'b0;
            cmd_reg         <= lpa_pkg::CMD_NOP;
            sel_reg         <= lpa_pkg::LIST_ACTIVE;
        end
        else
        begin
            state_reg       <= state_next;
            init_cnt_reg    <= init_cnt_next;
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            out_valid_reg   <= out_valid_next;
            cmd_reg         <= cmd_next;
            sel_reg         <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        entry_bad_reg  <= entry_bad_next;
        group_reg      <= group_next;
        old_group_reg  <= old_group_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        link_e_reg     <= link_e_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/lpa_checker.sv
// lpa_port_checks: port-level assertions for linked_pool_allocator, bound to the top.
// Depends on lpa_pkg (status codes).
`default_nettype none

module lpa_port_checks (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          status,
    input  wire logic [lpa_pkg::ENTRY_W-1:0]   result_index
);

    // transactions taken in but not yet delivered
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an input transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(result_index)))
        else $error("stalled result changed or dropped");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == lpa_pkg::STATUS_FULL)) |-> (result_index == '0))
        else $error("pool-full result carries a nonzero index");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without a pending input transaction");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd2) |-> (!in_ready && out_valid))
        else $error("more than one transaction in work beside a waiting result");

endmodule

bind linked_pool_allocator lpa_port_checks u_lpa_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_index (result_index)
);

`default_nettype wire

// File: dv/lpa_checker.sv
`timescale 1ns / 100ps
// lpa_checker: watches the command and reply channels of linked_pool_allocator,
// keeps its own copy of the free, active and group lists and checks every reply.
// Depends on lpa_pkg for field widths, command and status codes.

module lpa_checker #(
    parameter int POOL_SIZE   = 64,
    parameter int GROUP_COUNT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [lpa_pkg::CMD_W-1:0]     cmd,
    input  wire logic [lpa_pkg::ENTRY_W-1:0]   entry_index,
    input  wire logic [lpa_pkg::GROUP_W-1:0]   group_index,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          status,
    input  wire logic [lpa_pkg::ENTRY_W-1:0]   result_index,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 full_seen,
    output logic [POOL_SIZE-1:0]               alloc_mask
);

    localparam int LINK_W    = $clog2(POOL_SIZE + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

    typedef struct packed {
        logic                        status;
        logic [lpa_pkg::ENTRY_W-1:0] index;
    } reply_t;

    // pool image: NIL terminates every list
    logic [LINK_W-1:0]           free_head;
    logic [LINK_W-1:0]           active_head;
    logic [LINK_W-1:0]           active_next [POOL_SIZE];
    logic [LINK_W-1:0]           group_next  [POOL_SIZE];
    logic [lpa_pkg::GROUP_W-1:0] owner_group [POOL_SIZE];
    logic [LINK_W-1:0]           group_first [GROUP_COUNT];
    logic [POOL_SIZE-1:0]        allocated;

    reply_t replies_due[$];
    int     mismatches;
    int     fulls;

    task automatic report(input string what);
        $display("[%0t] lpa mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic int link_of(input lpa_pkg::list_sel_t which, input int i);
        return (which == lpa_pkg::LIST_ACTIVE) ? int'(active_next[i]) : int'(group_next[i]);
    endfunction

    task automatic push_group(input int e, input int g);
        owner_group[e] = lpa_pkg::GROUP_W'(g);
        group_next[e]  = group_first[g];
        group_first[g] = LINK_W'(e);
    endtask

    // bounded walk; an entry that is not found leaves the list alone
    task automatic unlink(input lpa_pkg::list_sel_t which, input int g, input int e);
        int cur;
        int steps;
        bit found;
        cur = (which == lpa_pkg::LIST_ACTIVE) ? int'(active_head) : int'(group_first[g]);
        if (cur == e)
        begin
            if (which == lpa_pkg::LIST_ACTIVE)
                active_head = LINK_W'(link_of(which, e));
            else
                group_first[g] = LINK_W'(link_of(which, e));
        end
        else
        begin
            found = 1'b0;
            steps = 0;
            while (!found && cur < POOL_SIZE && steps < POOL_SIZE)
            begin
                if (link_of(which, cur) == e)
                begin
                    if (which == lpa_pkg::LIST_ACTIVE)
                        active_next[cur] = active_next[e];
                    else
                        group_next[cur] = group_next[e];
                    found = 1'b1;
                end
                else
                    cur = link_of(which, cur);
                steps++;
            end
        end
    endtask

    task automatic apply_cmd(input logic [lpa_pkg::CMD_W-1:0] c,
                             input logic [lpa_pkg::ENTRY_W-1:0] ei,
                             input logic [lpa_pkg::GROUP_W-1:0] gi, output reply_t r);
        int e;
        int g;
        int prev;
        e = int'(ei);
        g = int'(gi) % GROUP_COUNT;
        r = '0;
        r.status = lpa_pkg::STATUS_DONE;
        case (lpa_pkg::cmd_t'(c))
            lpa_pkg::CMD_CREATE:
            begin
                if (free_head >= POOL_SIZE)
                    r.status = lpa_pkg::STATUS_FULL;
                else
                begin
                    e = int'(free_head);
                    free_head = group_next[e];
                    push_group(e, g);
                    active_next[e] = active_head;
                    active_head = LINK_W'(e);
                    allocated[e] = 1'b1;
                    r.index = lpa_pkg::ENTRY_W'(e);
                end
            end
            lpa_pkg::CMD_KILL:
            begin
                if (e < POOL_SIZE && allocated[e])
                begin
                    prev = int'(owner_group[e]);
                    unlink(lpa_pkg::LIST_ACTIVE, 0, e);
                    unlink(lpa_pkg::LIST_GROUP, prev, e);
                    group_next[e] = free_head;
                    free_head = LINK_W'(e);
                    active_next[e] = NIL;
                    allocated[e] = 1'b0;
                end
            end
            lpa_pkg::CMD_MOVE:
            begin
                if (e < POOL_SIZE && allocated[e])
                begin
                    prev = int'(owner_group[e]);
                    unlink(lpa_pkg::LIST_GROUP, prev, e);
                    push_group(e, g);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            free_head   = '0;
            active_head = NIL;
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                group_next[i]  = (i == POOL_SIZE - 1) ? NIL : LINK_W'(i + 1);
                active_next[i] = NIL;
                owner_group[i] = '0;
            end
            for (int i = 0; i < GROUP_COUNT; i++)
                group_first[i] = NIL;
            allocated = '0;
            replies_due.delete();
            mismatches = 0;
            fulls      = 0;
            fail_count <= 0;
            pending    <= 0;
            full_seen  <= 0;
            alloc_mask <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    report($sformatf("reply with nothing outstanding: status %0d index %0d",
                                     status, result_index));
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.status)
                        report($sformatf("status %0d, wanted %0d", status, want.status));
                    if (result_index !== want.index)
                        report($sformatf("result_index %0d, wanted %0d",
                                         result_index, want.index));
                end
                if (status === lpa_pkg::STATUS_FULL)
                    fulls++;
            end
            if (in_valid && in_ready)
            begin
                apply_cmd(cmd, entry_index, group_index, want);
                replies_due.push_back(want);
            end
            fail_count <= mismatches;
            pending    <= replies_due.size();
            full_seen  <= fulls;
            alloc_mask <= allocated;
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// tb: drives create, kill and move transactions into linked_pool_allocator
// with bursty traffic and a stalling receiver; lpa_checker does the scoring.

module tb;

    localparam int POOL   = 64;
    localparam int GROUPS = 256;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [lpa_pkg::CMD_W-1:0]   cmd = '0;
    logic [lpa_pkg::ENTRY_W-1:0] entry_index = '0;
    logic [lpa_pkg::GROUP_W-1:0] group_index = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        status;
    logic [lpa_pkg::ENTRY_W-1:0] result_index;

    int              fail_count;
    int              pending;
    int              full_seen;
    logic [POOL-1:0] alloc_mask;

    int       burst_left = 0;
    int       cmd_count [4] = '{default: 0};
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    linked_pool_allocator #(
        .POOL_SIZE   (POOL),
        .GROUP_COUNT (GROUPS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .entry_index  (entry_index),
        .group_index  (group_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index)
    );

    lpa_checker #(
        .POOL_SIZE   (POOL),
        .GROUP_COUNT (GROUPS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .entry_index  (entry_index),
        .group_index  (group_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index),
        .fail_count   (fail_count),
        .pending      (pending),
        .full_seen    (full_seen),
        .alloc_mask   (alloc_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: switches between randomly chosen stall patterns
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_left % 16 == 0);
        endcase
    end

    task automatic send_cmd(input lpa_pkg::cmd_t c, input int e, input int g);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd         <= c;
        entry_index <= lpa_pkg::ENTRY_W'(e);
        group_index <= lpa_pkg::GROUP_W'(g);
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        cmd_count[c]++;
    endtask

    // hold off until every reply is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly a live entry so kills and moves really walk the lists
    function automatic int pick_entry();
        int start;
        if (alloc_mask != '0 && $urandom_range(0, 99) < 85)
        begin
            start = $urandom_range(0, POOL - 1);
            for (int k = 0; k < POOL; k++)
                if (alloc_mask[(start + k) % POOL])
                    return (start + k) % POOL;
        end
        return $urandom_range(0, (1 << lpa_pkg::ENTRY_W) - 1);
    endfunction

    // a few hot groups keep the group lists long
    function automatic int pick_group();
        if ($urandom_range(0, 99) < 65)
            return $urandom_range(0, 3);
        return $urandom_range(0, (1 << lpa_pkg::GROUP_W) - 1);
    endfunction

    task automatic random_phase(input int items, input int w_create, input int w_kill,
                                input int w_move);
        int r;
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < w_create)
                send_cmd(lpa_pkg::CMD_CREATE, $urandom_range(0, (1 << lpa_pkg::ENTRY_W) - 1),
                         pick_group());
            else if (r < w_create + w_kill)
                send_cmd(lpa_pkg::CMD_KILL, pick_entry(),
                         $urandom_range(0, (1 << lpa_pkg::GROUP_W) - 1));
            else if (r < w_create + w_kill + w_move)
                send_cmd(lpa_pkg::CMD_MOVE, pick_entry(), pick_group());
            else
                send_cmd(lpa_pkg::CMD_NOP, $urandom_range(0, (1 << lpa_pkg::ENTRY_W) - 1),
                         $urandom_range(0, (1 << lpa_pkg::GROUP_W) - 1));
        end
        drain();
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unused command, dead entries, head/middle/tail unlinks, reuse
        send_cmd(lpa_pkg::CMD_NOP,    63, 255);
        send_cmd(lpa_pkg::CMD_KILL,    5,  17);
        send_cmd(lpa_pkg::CMD_MOVE,    0,   7);
        send_cmd(lpa_pkg::CMD_CREATE, 63,   0);
        send_cmd(lpa_pkg::CMD_CREATE,  0, 255);
        send_cmd(lpa_pkg::CMD_CREATE,  0,   0);
        send_cmd(lpa_pkg::CMD_CREATE,  0,   0);
        send_cmd(lpa_pkg::CMD_MOVE,    0,   0);
        send_cmd(lpa_pkg::CMD_MOVE,    2, 255);
        send_cmd(lpa_pkg::CMD_KILL,    1,   0);
        send_cmd(lpa_pkg::CMD_KILL,    3, 255);
        send_cmd(lpa_pkg::CMD_CREATE,  0, 128);
        send_cmd(lpa_pkg::CMD_CREATE,  0,   1);
        send_cmd(lpa_pkg::CMD_KILL,    0,   0);
        send_cmd(lpa_pkg::CMD_MOVE,    2, 170);
        send_cmd(lpa_pkg::CMD_KILL,    2,   0);
        send_cmd(lpa_pkg::CMD_KILL,    2,   0);
        send_cmd(lpa_pkg::CMD_MOVE,   63,  85);
        send_cmd(lpa_pkg::CMD_NOP,     0,   0);
        send_cmd(lpa_pkg::CMD_CREATE, 42, 170);
        send_cmd(lpa_pkg::CMD_CREATE, 21,  85);
        drain();

        // run the pool dry so creates come back full
        for (int i = 0; i < POOL + 2; i++)
            send_cmd(lpa_pkg::CMD_CREATE, $urandom_range(0, (1 << lpa_pkg::ENTRY_W) - 1),
                     $urandom_range(0, 3));
        drain();

        random_phase(80, 40, 30, 25);
        random_phase(80, 70, 10, 15);
        random_phase(80, 15, 55, 25);
        random_phase(80, 20, 15, 60);
        random_phase(80, 35, 30, 30);

        repeat (2 * POOL + 16) @(posedge clk);
        $display("covered %0d creates, %0d kills, %0d moves, %0d unused commands",
                 cmd_count[lpa_pkg::CMD_CREATE], cmd_count[lpa_pkg::CMD_KILL],
                 cmd_count[lpa_pkg::CMD_MOVE], cmd_count[lpa_pkg::CMD_NOP]);
        $display("%0d creates came back with the pool full", full_seen);
        if (fail_count == 0)
            $display("linked_pool_allocator verification clean");
        else
            $display("linked_pool_allocator verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("run did not finish in time, %0d replies outstanding", pending);
        $display("linked_pool_allocator verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/lpa_pkg.sv
design/lpa_ram.sv
design/linked_pool_allocator.sv
design/lpa_checker.sv
dv/lpa_checker.sv
dv/tb.sv
